FILE: rtl/tse_pkg.sv
// shared types, constants and segment tables for the time segment encoder
`default_nettype none

package tse_pkg;

    // time limits in seconds
    localparam logic [18:0] SEC_MAX    = 19'd359999;
    localparam logic [18:0] MMSS_LIMIT = 19'd3599;
    localparam logic [18:0] MMSS_SAT   = 19'd5999;

    // segment constants, low seven bits only (bit 7 is handled apart)
    localparam logic [6:0] SEG_DASH  = 7'h08;
    localparam logic [6:0] SEG_BLANK = 7'h00;

    // heat state code that asks for the cooling icon
    localparam logic [1:0] HEAT_COOL = 2'd2;

    // ring steps in which the ring segment is forced on
    localparam logic [3:0] RING_ON_LO  = 4'd4;
    localparam logic [3:0] RING_ON_HI  = 4'd9;
    localparam logic [3:0] RING_ON_ALT = 4'd13;

    // reciprocal multipliers: x / 60 computed as (x >> 2) / 15
    localparam logic [17:0] DIV15_MUL_WIDE   = 18'd139811;  // 17 bit operand, shift 21
    localparam int          DIV15_SHIFT_WIDE = 21;
    localparam logic [11:0] DIV15_MUL_NARROW = 12'd2185;    // 11 bit operand, shift 15
    localparam int          DIV15_SHIFT_NARROW = 15;
    // x / 10 for x below 1029
    localparam logic [7:0]  DIV10_MUL   = 8'd205;
    localparam int          DIV10_SHIFT = 11;

    typedef struct packed {
        logic func;          // 0 set time, 1 actual time
        logic unit;          // 1 hours:minutes
        logic colon_hidden;
        logic icon_on;       // cooling icon requested and visible
        logic unset;
        logic blank;
        logic ring_bit;      // ring segment for the set-time group
    } t_flags;

    typedef struct packed {
        logic s2;  // load stage two
        logic s3;  // load stage three
        logic so;  // load result register
    } t_stage_en;

    function automatic logic [6:0] set_seg(input logic [3:0] d);
        logic [6:0] r;
        unique case (d)
            4'd0:    r = 7'h77;
            4'd1:    r = 7'h12;
            4'd2:    r = 7'h5d;
            4'd3:    r = 7'h5b;
            4'd4:    r = 7'h3a;
            4'd5:    r = 7'h6b;
            4'd6:    r = 7'h6f;
            4'd7:    r = 7'h52;
            4'd8:    r = 7'h7f;
            4'd9:    r = 7'h7b;
            default: r = SEG_BLANK;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] act_seg(input logic [3:0] d);
        logic [6:0] r;
        unique case (d)
            4'd0:    r = 7'h77;
            4'd1:    r = 7'h24;
            4'd2:    r = 7'h5d;
            4'd3:    r = 7'h6d;
            4'd4:    r = 7'h2e;
            4'd5:    r = 7'h6b;
            4'd6:    r = 7'h7b;
            4'd7:    r = 7'h25;
            4'd8:    r = 7'h7f;
            4'd9:    r = 7'h6f;
            default: r = SEG_BLANK;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tse_split.sv
// two pipeline stages that split the time value into high and low two-digit fields
`default_nettype none

module tse_split (
    input  wire logic              i_clk,
    input  wire tse_pkg::t_stage_en i_en,
    input  wire logic [18:0]       i_x,
    input  wire tse_pkg::t_flags   i_flags,
    output logic [6:0]             o_hi,
    output logic [5:0]             o_lo,
    output tse_pkg::t_flags        o_flags
);
    import tse_pkg::*;

    logic [34:0] n_prod1;
    logic [12:0] n_q1;
    logic [12:0] r_q1;
    logic [5:0]  r_xl;
    t_flags      r_f2;

    logic [22:0] n_prod2;
    logic [6:0]  n_q2;
    logic [18:0] n_q1x60;
    logic [12:0] n_q2x60;
    logic [5:0]  n_r1;
    logic [5:0]  n_r2;
    logic [6:0]  r_hi;
    logic [5:0]  r_lo;
    t_flags      r_f3;

    // stage two: q1 = x / 60
    assign n_prod1 = 35'(i_x[18:2]) * 35'(DIV15_MUL_WIDE);
    assign n_q1    = n_prod1[DIV15_SHIFT_WIDE +: 13];

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_q1 <= n_q1;
            r_xl <= i_x[5:0];
            r_f2 <= i_flags;
        end
    end

    // stage three: remainders and, for hours:minutes, q1 / 60
    assign n_q1x60 = {r_q1, 6'b0} - {4'b0, r_q1, 2'b0};
    assign n_r1    = r_xl - n_q1x60[5:0];
    assign n_prod2 = 23'(r_q1[12:2]) * 23'(DIV15_MUL_NARROW);
    assign n_q2    = n_prod2[DIV15_SHIFT_NARROW +: 7];
    assign n_q2x60 = {n_q2, 6'b0} - {4'b0, n_q2, 2'b0};
    assign n_r2    = r_q1[5:0] - n_q2x60[5:0];

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_hi <= r_f2.unit ? n_q2 : r_q1[6:0];
            r_lo <= r_f2.unit ? n_r2 : n_r1;
            r_f3 <= r_f2;
        end
    end

    assign o_hi    = r_hi;
    assign o_lo    = r_lo;
    assign o_flags = r_f3;

endmodule

`default_nettype wire

FILE: rtl/tse_seg.sv
// decimal digits, segment tables and marker bits into the result register
`default_nettype none

module tse_seg (
    input  wire logic              i_clk,
    input  wire tse_pkg::t_stage_en i_en,
    input  wire logic [6:0]        i_hi,
    input  wire logic [5:0]        i_lo,
    input  wire tse_pkg::t_flags   i_flags,
    output logic                   o_group,
    output logic [31:0]            o_segs,
    output logic                   o_unit
);
    import tse_pkg::*;

    logic [14:0] n_ph;
    logic [13:0] n_pl;
    logic [3:0]  n_d [4];
    logic [6:0]  n_low [4];
    logic [7:0]  n_b [4];
    logic [31:0] r_segs;
    logic        r_group;
    logic        r_unit;

    assign n_ph   = 15'(i_hi) * 15'(DIV10_MUL);
    assign n_pl   = 14'(i_lo) * 14'(DIV10_MUL);
    assign n_d[0] = n_ph[DIV10_SHIFT +: 4];
    assign n_d[2] = {1'b0, n_pl[DIV10_SHIFT +: 3]};
    assign n_d[1] = 4'(i_hi - ({n_d[0], 3'b0} + {2'b0, n_d[0], 1'b0}));
    assign n_d[3] = 4'(i_lo - ({n_d[2][2:0], 3'b0} + {2'b0, n_d[2][2:0], 1'b0}));

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (i_flags.func) begin
                n_low[i] = i_flags.unset ? SEG_DASH : act_seg(n_d[i]);
            end else if (i_flags.blank) begin
                n_low[i] = SEG_BLANK;
            end else begin
                n_low[i] = i_flags.unset ? SEG_DASH : set_seg(n_d[i]);
            end
        end
        if (i_flags.func) begin
            n_b[0] = {i_flags.icon_on, n_low[0]};
            n_b[1] = {1'b0, n_low[1]};
            n_b[2] = {!i_flags.colon_hidden, n_low[2]};
            n_b[3] = {1'b0, n_low[3]};
        end else begin
            n_b[0] = {i_flags.ring_bit, n_low[0]};
            n_b[1] = {!i_flags.colon_hidden && !i_flags.blank, n_low[1]};
            n_b[2] = {!i_flags.unit, n_low[2]};
            n_b[3] = {i_flags.unit, n_low[3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.so) begin
            r_segs  <= {n_b[3], n_b[2], n_b[1], n_b[0]};
            r_group <= i_flags.func;
            r_unit  <= i_flags.unit;
        end
    end

    assign o_segs  = r_segs;
    assign o_group = r_group;
    assign o_unit  = r_unit;

endmodule

`default_nettype wire

FILE: rtl/time_segment_encoder.sv
// top level: four-digit seven-segment encoder for the set-time and actual-time groups
// path: input register, divide-by-60 stage, second split stage, result register
// throughput: one request per cycle while the output is not stalled by i_m_axis_tready;
//   each stage loads when empty or when its successor loads
// reset: synchronous active-low i_rst_n clears all stage valid bits and the stored unit
//   (minutes:seconds); payload registers are not reset
`default_nettype none

module time_segment_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // seconds[18:0], colon_hidden[19], icon_blink[20], heat_state[22:21], running[23],
    // unset[24], blank[25], ring_active[26], ring_step[30:27], ring_fixed[31]
    input  wire logic [31:0] i_s_axis_tdata,
    // func[0]
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // seg_first[7:0], seg_second[15:8], seg_third[23:16], seg_fourth[31:24],
    // unit_minutes[32], zero fill[39:33]
    output logic [39:0]      o_m_axis_tdata,
    // group[0]
    output logic             o_m_axis_tuser
);
    import tse_pkg::*;

    // request fields
    logic [18:0] seconds;
    logic [1:0]  heat_state;
    logic [3:0]  ring_step;
    logic        ring_active;
    logic        ring_fixed;
    logic        func;
    logic        accept;

    // pipeline control
    logic        r_v1, r_v2, r_v3, r_vo;
    logic        n_en1;
    t_stage_en   n_en;

    // stored display unit, set by every set-time request
    logic        r_unit;

    // stage one payload
    logic [18:0] n_sat;
    logic        n_unit;
    logic [18:0] n_x;
    logic        n_ring_step_on;
    t_flags      n_flags;
    logic [18:0] r_x1;
    t_flags      r_f1;

    // split stage outputs
    logic [6:0]  hi;
    logic [5:0]  lo;
    t_flags      f3;

    logic [31:0] segs;
    logic        unit_out;

    assign seconds     = i_s_axis_tdata[18:0];
    assign heat_state  = i_s_axis_tdata[22:21];
    assign ring_active = i_s_axis_tdata[26];
    assign ring_step   = i_s_axis_tdata[30:27];
    assign ring_fixed  = i_s_axis_tdata[31];
    assign func        = i_s_axis_tuser;

    // a stage takes new data when it is empty or its contents move on this cycle
    assign n_en.so = !r_vo || i_m_axis_tready;
    assign n_en.s3 = !r_v3 || n_en.so;
    assign n_en.s2 = !r_v2 || n_en.s3;
    assign n_en1   = !r_v1 || n_en.s2;

    assign o_s_axis_tready = n_en1;
    assign accept          = i_s_axis_tvalid && n_en1;

    // saturate at 99:59:59, choose the unit, and clamp minutes:seconds at 99:59
    assign n_sat  = (seconds > SEC_MAX) ? SEC_MAX : seconds;
    assign n_unit = func ? r_unit : (n_sat > MMSS_LIMIT);
    assign n_x    = (!n_unit && (n_sat > MMSS_SAT)) ? MMSS_SAT : n_sat;

    // ring segment: forced on in the lit steps, otherwise off unless shown steadily
    assign n_ring_step_on = ((ring_step >= RING_ON_LO) && (ring_step <= RING_ON_HI))
                            || (ring_step == RING_ON_ALT);

    always_comb begin
        n_flags.func         = func;
        n_flags.unit         = n_unit;
        n_flags.colon_hidden = i_s_axis_tdata[19];
        n_flags.icon_on      = !i_s_axis_tdata[20] && (heat_state == HEAT_COOL)
                               && i_s_axis_tdata[23];
        n_flags.unset        = i_s_axis_tdata[24];
        n_flags.blank        = i_s_axis_tdata[25];
        n_flags.ring_bit     = ring_active && (n_ring_step_on || ring_fixed);
    end

    // valid bits and the stored unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vo   <= 1'b0;
            r_unit <= 1'b0;
        end else begin
            if (n_en1) begin
                r_v1 <= i_s_axis_tvalid;
            end
            if (n_en.s2) begin
                r_v2 <= r_v1;
            end
            if (n_en.s3) begin
                r_v3 <= r_v2;
            end
            if (n_en.so) begin
                r_vo <= r_v3;
            end
            if (accept && !func) begin
                r_unit <= n_unit;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (n_en1) begin
            r_x1 <= n_x;
            r_f1 <= n_flags;
        end
    end

    tse_split u_split (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_x     (r_x1),
        .i_flags (r_f1),
        .o_hi    (hi),
        .o_lo    (lo),
        .o_flags (f3)
    );

    tse_seg u_seg (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_hi    (hi),
        .i_lo    (lo),
        .i_flags (f3),
        .o_group (o_m_axis_tuser),
        .o_segs  (segs),
        .o_unit  (unit_out)
    );

    assign o_m_axis_tvalid = r_vo;
    assign o_m_axis_tdata  = {7'b0, unit_out, segs};

endmodule

`default_nettype wire

FILE: rtl/tse_checker.sv
// port-level checks for the time segment encoder and their bind
`default_nettype none

module tse_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [39:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // set-time results carry exactly one unit dot, matching the unit bit
    a_unit_dot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            (o_m_axis_tdata[31] == o_m_axis_tdata[32]) &&
            (o_m_axis_tdata[23] != o_m_axis_tdata[32]))
        else $error("unit dot does not match unit");

    // actual-time results never light the second and fourth top segments
    a_act_tops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |->
            !o_m_axis_tdata[15] && !o_m_axis_tdata[31] && (o_m_axis_tdata[39:33] == 7'd0))
        else $error("actual-time top segment set");

endmodule

bind time_segment_encoder tse_checker u_tse_checker (.*);

`default_nettype wire
